/* hw/rtl/ttmp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttmp_pkg: shared definitions for the telemetry text message parser
// Character codes, message kinds, record layout, item and result types and
// the decimal accumulate helpers.
// ----------------------------------------------------------------------------
package ttmp_pkg;

  localparam int MESSAGE_CHARS_DEF = 24;

  // ASCII codes the classifier and field parsers look for.
  localparam logic [7:0] CH_LOWER_L = 8'h6C;  // 'l'
  localparam logic [7:0] CH_LOWER_K = 8'h6B;  // 'k'
  localparam logic [7:0] CH_UPPER_V = 8'h56;  // 'V'
  localparam logic [7:0] CH_UPPER_T = 8'h54;  // 'T'
  localparam logic [7:0] CH_UPPER_X = 8'h58;  // 'X'
  localparam logic [7:0] CH_UPPER_M = 8'h4D;  // 'M'
  localparam logic [7:0] CH_BAR     = 8'h7C;  // '|'
  localparam logic [7:0] CH_MINUS   = 8'h2D;  // '-'
  localparam logic [7:0] CH_ZERO    = 8'h30;  // '0'
  localparam logic [7:0] CH_NUL     = 8'h00;

  // Slots of the stored record.
  localparam int REC_BATTERY  = 0;
  localparam int REC_PITCH    = 1;
  localparam int REC_THROTTLE = 4;
  localparam int REC_DEPTH    = 5;

  typedef enum logic [2:0] {
    KIND_NONE     = 3'd0,
    KIND_LINK     = 3'd1,
    KIND_BATTERY  = 3'd2,
    KIND_ATTITUDE = 3'd3,
    KIND_THROTTLE = 3'd4
  } kind_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_message;
  } item_t;

  typedef struct packed {
    kind_t              message_kind;
    logic               link_ready;
    logic [9:0]         battery_value;
    logic signed [15:0] pitch_value;
    logic signed [15:0] roll_value;
    logic signed [15:0] yaw_value;
    logic [15:0]        throttle_level;
  } result_t;

  // acc * 10 + (c - '0'), wrapped to 16 bits; any character counts as a digit.
  function automatic logic [15:0] add_digit(input logic [15:0] acc, input logic [7:0] c);
    add_digit = (acc << 3) + (acc << 1) + {8'd0, c} - {8'd0, CH_ZERO};
  endfunction

  function automatic logic [15:0] apply_sign(input logic [15:0] acc, input logic neg);
    apply_sign = neg ? (16'd0 - acc) : acc;
  endfunction

  // Attitude field index to angle slot; the unused code folds back to pitch.
  function automatic logic [1:0] field_slot(input logic [1:0] idx);
    field_slot = (idx == 2'd3) ? 2'd0 : idx;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/telemetry_text_message_parser_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// telemetry_text_message_parser_core: telemetry text message parser
// Parses character-serial telemetry messages into a kind and a stored record.
// ----------------------------------------------------------------------------
// The block takes one character item per clock cycle, with no gaps needed
// between items or messages. A character is held in the input register
// until the parser consumes it; the parser's state update is a single
// combinational pass into the message registers, and its result is loaded
// into the output register as the end-of-message item is consumed. Only
// the item that ends a message produces a result, and that result carries
// the message kind together with the full stored record. The input side
// stalls only when a finished result is still waiting at the output and
// the next item to be consumed also ends a message; characters that do
// not end a message keep flowing while a result waits.
module telemetry_text_message_parser_core #(
  parameter int MESSAGE_CHARS = ttmp_pkg::MESSAGE_CHARS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_char_byte,
  input  wire logic        in_end_of_message,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_message_kind,
  output logic             out_link_ready,
  output logic [9:0]       out_battery_value,
  output logic signed [15:0] out_pitch_value,
  output logic signed [15:0] out_roll_value,
  output logic signed [15:0] out_yaw_value,
  output logic [15:0]      out_throttle_level
);
  import ttmp_pkg::*;

  item_t   in_item;
  item_t   stage_item;
  logic    stage_valid;
  logic    take;
  logic    out_space;
  result_t parse_result;
  result_t out_result;

  assign in_item.char_byte      = in_char_byte;
  assign in_item.end_of_message = in_end_of_message;

  // A held character is consumed whenever its result, if it makes one,
  // has room in the output register.
  assign take = stage_valid && (!stage_item.end_of_message || out_space);

  ttmp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (take),
    .item_valid (stage_valid),
    .item       (stage_item)
  );

  ttmp_parser #(
    .MESSAGE_CHARS (MESSAGE_CHARS)
  ) u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (take),
    .item   (stage_item),
    .result (parse_result)
  );

  ttmp_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (take && stage_item.end_of_message),
    .result_in  (parse_result),
    .space      (out_space),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result_out (out_result)
  );

  assign out_message_kind   = out_result.message_kind;
  assign out_link_ready     = out_result.link_ready;
  assign out_battery_value  = out_result.battery_value;
  assign out_pitch_value    = out_result.pitch_value;
  assign out_roll_value     = out_result.roll_value;
  assign out_yaw_value      = out_result.yaw_value;
  assign out_throttle_level = out_result.throttle_level;

endmodule
`default_nettype wire

/* hw/rtl/ttmp_in_reg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttmp_in_reg: input register
// Captures one character item and holds it until the parser consumes it.
// ----------------------------------------------------------------------------
module ttmp_in_reg (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire ttmp_pkg::item_t in_item,
  input  wire logic           take,
  output logic                item_valid,
  output ttmp_pkg::item_t     item
);
  import ttmp_pkg::*;

  logic  valid_r;
  item_t item_r;

  assign in_ready   = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/ttmp_parser.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttmp_parser: message state and record
// Updates per-message state for each character and, on the last character,
// classifies the message, updates the record and forms the result.
// ----------------------------------------------------------------------------
module ttmp_parser #(
  parameter int MESSAGE_CHARS = ttmp_pkg::MESSAGE_CHARS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            fire,
  input  wire ttmp_pkg::item_t item,
  output ttmp_pkg::result_t    result
);
  import ttmp_pkg::*;

  localparam int PosW = $clog2(MESSAGE_CHARS + 1);

  logic [PosW-1:0] char_position_r, char_position_nxt;
  logic [7:0]      header_chars_r [4];
  logic [7:0]      header_chars_nxt [4];
  logic [1:0]      field_index_r, field_index_nxt;
  logic [15:0]     digit_accumulator_r, digit_accumulator_nxt;
  logic            negative_flag_r, negative_flag_nxt;
  logic            field_done_r, field_done_nxt;
  logic            field_fresh_r, field_fresh_nxt;
  logic [15:0]     stored_record_r [REC_DEPTH];
  logic [15:0]     stored_record_nxt [REC_DEPTH];
  logic            link_flag_r, link_flag_nxt;
  kind_t           kind;
  logic [7:0]      c;

  assign c = item.char_byte;

  always_comb begin
    char_position_nxt     = char_position_r;
    header_chars_nxt      = header_chars_r;
    field_index_nxt       = field_index_r;
    digit_accumulator_nxt = digit_accumulator_r;
    negative_flag_nxt     = negative_flag_r;
    field_done_nxt        = field_done_r;
    field_fresh_nxt       = field_fresh_r;
    stored_record_nxt     = stored_record_r;
    link_flag_nxt         = link_flag_r;
    kind                  = KIND_NONE;

    if (fire) begin
      // Character phase: only the first MESSAGE_CHARS characters count.
      if (char_position_r < PosW'(MESSAGE_CHARS)) begin
        if (char_position_r < PosW'(4)) begin
          header_chars_nxt[char_position_r[1:0]] = c;
        end
        if (header_chars_nxt[0] == CH_UPPER_M) begin
          if (char_position_r >= PosW'(1) && !field_done_r) begin
            if (field_fresh_r && c == CH_MINUS) begin
              negative_flag_nxt = 1'b1;
              field_fresh_nxt   = 1'b0;
            end else begin
              field_fresh_nxt = 1'b0;
              if (c == CH_BAR) begin
                for (int k = 0; k < 3; k++) begin
                  if (field_slot(field_index_r) == 2'(k)) begin
                    stored_record_nxt[REC_PITCH + k] =
                      apply_sign(digit_accumulator_r, negative_flag_r);
                  end
                end
                digit_accumulator_nxt = 16'd0;
                negative_flag_nxt     = 1'b0;
                field_fresh_nxt       = 1'b1;
                if (field_index_r >= 2'd2) begin
                  field_done_nxt = 1'b1;
                end else begin
                  field_index_nxt = field_index_r + 2'd1;
                end
              end else begin
                digit_accumulator_nxt = add_digit(digit_accumulator_r, c);
              end
            end
          end
        end else if (header_chars_nxt[0] == CH_UPPER_V && char_position_r >= PosW'(3)) begin
          if (header_chars_nxt[3] == CH_UPPER_T) begin
            if (char_position_r >= PosW'(4) && char_position_r <= PosW'(6)) begin
              digit_accumulator_nxt = add_digit(digit_accumulator_r, c);
            end
          end else if (header_chars_nxt[2] == CH_UPPER_X && !field_done_r) begin
            if (c == CH_BAR) begin
              stored_record_nxt[REC_THROTTLE] = digit_accumulator_r;
              field_done_nxt                  = 1'b1;
            end else begin
              digit_accumulator_nxt = add_digit(digit_accumulator_r, c);
            end
          end
        end
        char_position_nxt = char_position_r + PosW'(1);
      end

      // End of message: classify, close open fields, then clear.
      if (item.end_of_message) begin
        if (header_chars_nxt[0] == CH_LOWER_L && header_chars_nxt[3] == CH_LOWER_K) begin
          kind          = KIND_LINK;
          link_flag_nxt = 1'b1;
        end else if (header_chars_nxt[0] == CH_UPPER_V &&
                     header_chars_nxt[3] == CH_UPPER_T) begin
          kind = KIND_BATTERY;
          // Digit positions that never arrived read as the NUL character,
          // each one a v*10 - 48 step. One, two or three such steps are
          // folded into a single scale and offset.
          if (char_position_nxt <= PosW'(4)) begin
            digit_accumulator_nxt = digit_accumulator_nxt * 16'd1000 - 16'd5328;
          end else if (char_position_nxt == PosW'(5)) begin
            digit_accumulator_nxt = digit_accumulator_nxt * 16'd100 - 16'd528;
          end else if (char_position_nxt == PosW'(6)) begin
            digit_accumulator_nxt = digit_accumulator_nxt * 16'd10 - 16'd48;
          end
          stored_record_nxt[REC_BATTERY] = digit_accumulator_nxt;
        end else if (header_chars_nxt[0] == CH_UPPER_M) begin
          kind = KIND_ATTITUDE;
          if (!field_done_nxt) begin
            for (int k = 0; k < 3; k++) begin
              if (field_slot(field_index_nxt) == 2'(k)) begin
                stored_record_nxt[REC_PITCH + k] =
                  apply_sign(digit_accumulator_nxt, negative_flag_nxt);
              end else if (2'(k) > field_index_nxt) begin
                stored_record_nxt[REC_PITCH + k] = 16'd0;
              end
            end
          end
        end else if (header_chars_nxt[0] == CH_UPPER_V &&
                     header_chars_nxt[2] == CH_UPPER_X) begin
          kind = KIND_THROTTLE;
          if (!field_done_nxt) begin
            stored_record_nxt[REC_THROTTLE] = digit_accumulator_nxt;
          end
        end

        char_position_nxt     = '0;
        header_chars_nxt      = '{default: 8'd0};
        field_index_nxt       = 2'd0;
        digit_accumulator_nxt = 16'd0;
        negative_flag_nxt     = 1'b0;
        field_done_nxt        = 1'b0;
        field_fresh_nxt       = 1'b1;
      end
    end
  end

  assign result.message_kind   = kind;
  assign result.link_ready     = link_flag_nxt;
  assign result.battery_value  = stored_record_nxt[REC_BATTERY][9:0];
  assign result.pitch_value    = stored_record_nxt[REC_PITCH];
  assign result.roll_value     = stored_record_nxt[REC_PITCH + 1];
  assign result.yaw_value      = stored_record_nxt[REC_PITCH + 2];
  assign result.throttle_level = stored_record_nxt[REC_THROTTLE];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_position_r     <= '0;
      header_chars_r      <= '{default: 8'd0};
      field_index_r       <= 2'd0;
      digit_accumulator_r <= 16'd0;
      negative_flag_r     <= 1'b0;
      field_done_r        <= 1'b0;
      field_fresh_r       <= 1'b1;
      stored_record_r     <= '{default: 16'd0};
      link_flag_r         <= 1'b0;
    end else begin
      char_position_r     <= char_position_nxt;
      header_chars_r      <= header_chars_nxt;
      field_index_r       <= field_index_nxt;
      digit_accumulator_r <= digit_accumulator_nxt;
      negative_flag_r     <= negative_flag_nxt;
      field_done_r        <= field_done_nxt;
      field_fresh_r       <= field_fresh_nxt;
      stored_record_r     <= stored_record_nxt;
      link_flag_r         <= link_flag_nxt;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/ttmp_out_reg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttmp_out_reg: result register
// Holds one finished result until the consumer takes it.
// ----------------------------------------------------------------------------
module ttmp_out_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire ttmp_pkg::result_t result_in,
  output logic                   space,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ttmp_pkg::result_t      result_out
);
  import ttmp_pkg::*;

  logic    valid_r;
  result_t result_r;

  assign space      = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign result_out = result_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (space) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (space && load) begin
      result_r <= result_in;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/ttmp_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttmp_checker: port-level checks for the telemetry text message parser
// Watches both channels for handshake and record consistency.
// ----------------------------------------------------------------------------
module ttmp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [7:0]  in_char_byte,
  input wire logic        in_end_of_message,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  out_message_kind,
  input wire logic        out_link_ready,
  input wire logic [9:0]  out_battery_value,
  input wire logic signed [15:0] out_pitch_value,
  input wire logic signed [15:0] out_roll_value,
  input wire logic signed [15:0] out_yaw_value,
  input wire logic [15:0] out_throttle_level
);
  import ttmp_pkg::*;

  logic seen_link_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_link_r <= 1'b0;
    end else if (out_valid && out_ready && out_link_ready) begin
      seen_link_r <= 1'b1;
    end
  end

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_char_byte) &&
      $stable(in_end_of_message))
    else $error("input item changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_message_kind) &&
      $stable(out_link_ready) && $stable(out_battery_value) &&
      $stable(out_pitch_value) && $stable(out_roll_value) &&
      $stable(out_yaw_value) && $stable(out_throttle_level))
    else $error("result changed while stalled");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_message_kind <= KIND_THROTTLE)
    else $error("message kind out of range");

  a_link_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_message_kind == KIND_LINK |-> out_link_ready)
    else $error("link ready message without link flag");

  a_link_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_link_r |-> out_link_ready)
    else $error("link flag dropped after being set");

endmodule

bind telemetry_text_message_parser_core ttmp_checker u_ttmp_checker (.*);
`default_nettype wire
